// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication, off while reset is high
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/cssu_pkg.sv =====
// ---------------------------------------------------------------------------
// cssu_pkg
// Types, codes and helpers of the convex support point search unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cssu_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MAT,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_WAIT,
    ST_OUT
  } state_t;

  localparam int SQRT_ITER = 32;
  localparam int DIV_W     = 63;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] bias;
  } req_t;

  typedef struct packed {
    logic signed [31:0] sup_x;
    logic signed [31:0] sup_y;
    logic signed [31:0] sup_z;
    logic [5:0]         best_index;
    logic               empty_set;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic query_load;
    logic mul;
    logic mat_load;
    logic scan;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
    logic pipe_busy;
    logic sqrt_busy;
    logic div_busy;
    logic out_busy;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cssu_req_if.sv =====
// ---------------------------------------------------------------------------
// cssu_req_if
// Request channel: op code, vector, pose and bias.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface cssu_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] bias;

  modport source (output valid, op, vec_x, vec_y, vec_z, pos_x, pos_y, pos_z,
                  quat_w, quat_x, quat_y, quat_z, bias, input ready);
  modport sink (input valid, op, vec_x, vec_y, vec_z, pos_x, pos_y, pos_z,
                quat_w, quat_x, quat_y, quat_z, bias, output ready);
endinterface
`default_nettype wire

// ===== rtl/cssu_rsp_if.sv =====
// ---------------------------------------------------------------------------
// cssu_rsp_if
// Result channel: support point, winning index and empty flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface cssu_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sup_x;
  logic signed [31:0] sup_y;
  logic signed [31:0] sup_z;
  logic [5:0]         best_index;
  logic               empty_set;

  modport source (output valid, sup_x, sup_y, sup_z, best_index, empty_set,
                  input ready);
  modport sink (input valid, sup_x, sup_y, sup_z, best_index, empty_set,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/cssu_sqrt.sv =====
// ---------------------------------------------------------------------------
// cssu_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cssu_sqrt
  import cssu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic [31:0] root,
  output logic        busy
);

  logic [63:0] rad_sh;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic [35:0] rem_s;
  logic [35:0] trial;

  assign rem_s = {rem, rad_sh[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'(SQRT_ITER - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
      cnt    <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[61:0], 2'b00};
      cnt    <= cnt + 5'd1;
      if (rem_s >= trial) begin
        rem  <= 34'(rem_s - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= 34'(rem_s);
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cssu_div.sv =====
// ---------------------------------------------------------------------------
// cssu_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero; a zero divisor gives a zero quotient.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cssu_div
  import cssu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [31:0]        divisor,
  output logic signed [63:0] quot,
  output logic               busy
);

  logic [DIV_W-1:0] num;
  logic [DIV_W-1:0] q;
  logic [31:0]      den;
  logic [31:0]      rem;
  logic             neg;
  logic             zdiv;
  logic [5:0]       cnt;
  logic [63:0]      mag;
  logic [32:0]      rem_s;

  assign mag   = dividend[63] ? 64'(-dividend) : 64'(dividend);
  assign rem_s = {rem, num[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 6'(DIV_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= mag[DIV_W-1:0];
      neg  <= dividend[63];
      zdiv <= (divisor == '0);
      den  <= divisor;
      rem  <= '0;
      q    <= '0;
      cnt  <= '0;
    end else if (busy) begin
      num <= {num[DIV_W-2:0], 1'b0};
      cnt <= cnt + 6'd1;
      if (rem_s >= {1'b0, den}) begin
        rem <= 32'(rem_s - {1'b0, den});
        q   <= {q[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_s[31:0];
        q   <= {q[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (zdiv) begin
      quot = '0;
    end else if (neg) begin
      quot = -$signed({1'b0, q});
    end else begin
      quot = $signed({1'b0, q});
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cssu_ctrl.sv =====
// ---------------------------------------------------------------------------
// cssu_ctrl
// Sequencer: decodes requests and steps the datapath through a query.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cssu_ctrl
  import cssu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_op,
  input  sts_t       sts,
  output logic       req_ready,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && req_op == OP_QUERY) begin
          state_next = sts.cnt_zero ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_MAT;
      ST_MAT:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy && !sts.sqrt_busy) state_next = ST_DIV;
      end
      ST_DIV:   state_next = ST_WAIT;
      ST_WAIT: begin
        if (!sts.div_busy) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (req_op)
            OP_CLEAR:  cmd.clear      = 1'b1;
            OP_APPEND: cmd.append     = 1'b1;
            OP_QUERY:  cmd.query_load = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MUL:   cmd.mul       = 1'b1;
      ST_MAT:   cmd.mat_load  = 1'b1;
      ST_SCAN:  cmd.scan      = 1'b1;
      ST_DIV:   cmd.div_start = 1'b1;
      ST_OUT:   cmd.out_load  = !sts.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/cssu_dp.sv =====
// ---------------------------------------------------------------------------
// cssu_dp
// Datapath: point store, rotation matrix, scan pipeline, length and offset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cssu_dp
  import cssu_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t pld,
  input  logic rsp_ready,
  output sts_t sts,
  output rsp_t rsp_data,
  output logic rsp_valid
);

  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int CW1 = CW + 1;

  // point store
  point_t         mem [MAX_POINTS];
  logic [CW-1:0]  count;
  logic           store_ok;

  assign store_ok = (count < CW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append && store_ok) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && store_ok) begin
      mem[count[IW-1:0]] <= '{x: pld.vec_x, y: pld.vec_y, z: pld.vec_z};
    end
  end

  // query operands
  logic signed [31:0] dir [3];
  logic signed [31:0] pos [3];
  logic signed [31:0] qw, qx, qy, qz, bias;

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      dir[0] <= pld.vec_x;
      dir[1] <= pld.vec_y;
      dir[2] <= pld.vec_z;
      pos[0] <= pld.pos_x;
      pos[1] <= pld.pos_y;
      pos[2] <= pld.pos_z;
      qw     <= pld.quat_w;
      qx     <= pld.quat_x;
      qy     <= pld.quat_y;
      qz     <= pld.quat_z;
      bias   <= pld.bias;
    end
  end

  // quaternion products, squared direction and direction times bias
  logic signed [63:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  logic signed [63:0] vsq [3];
  logic signed [63:0] vb  [3];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_ww <= qw * qw;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_xy <= qx * qy;
      p_wz <= qw * qz;
      p_xz <= qx * qz;
      p_wy <= qw * qy;
      p_yz <= qy * qz;
      p_wx <= qw * qx;
      for (int i = 0; i < 3; i++) begin
        vsq[i] <= dir[i] * dir[i];
        vb[i]  <= dir[i] * bias;
      end
    end
  end

  // products floored to Q.30
  logic signed [35:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
  logic signed [35:0] m_raw [9];
  logic [63:0]        len2;

  assign e_ww = 36'($signed(p_ww[63:30]));
  assign e_xx = 36'($signed(p_xx[63:30]));
  assign e_yy = 36'($signed(p_yy[63:30]));
  assign e_zz = 36'($signed(p_zz[63:30]));
  assign e_xy = 36'($signed(p_xy[63:30]));
  assign e_wz = 36'($signed(p_wz[63:30]));
  assign e_xz = 36'($signed(p_xz[63:30]));
  assign e_wy = 36'($signed(p_wy[63:30]));
  assign e_yz = 36'($signed(p_yz[63:30]));
  assign e_wx = 36'($signed(p_wx[63:30]));

  always_comb begin
    m_raw[0] = e_ww + e_xx - e_yy - e_zz;
    m_raw[1] = (e_xy - e_wz) <<< 1;
    m_raw[2] = (e_xz + e_wy) <<< 1;
    m_raw[3] = (e_xy + e_wz) <<< 1;
    m_raw[4] = e_ww - e_xx + e_yy - e_zz;
    m_raw[5] = (e_yz - e_wx) <<< 1;
    m_raw[6] = (e_xz - e_wy) <<< 1;
    m_raw[7] = (e_yz + e_wx) <<< 1;
    m_raw[8] = e_ww - e_xx - e_yy + e_zz;
  end

  assign len2 = 64'(vsq[0]) + 64'(vsq[1]) + 64'(vsq[2]);

  logic signed [31:0] rm [9];

  always_ff @(posedge clk) begin
    if (cmd.mat_load) begin
      for (int i = 0; i < 9; i++) begin
        rm[i] <= sat32(66'(m_raw[i]));
      end
    end
  end

  // direction length
  logic [31:0] len;
  logic        sqrt_busy;

  cssu_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mat_load),
    .rad   (len2),
    .root  (len),
    .busy  (sqrt_busy)
  );

  // scan pipeline: read, rotate, translate, dot, compare
  logic [IW-1:0]      rd_addr;
  point_t             rd_q;
  logic               v1, v2, v3, v4;
  logic [IW-1:0]      idx1, idx2, idx3, idx4;
  logic signed [63:0] pr [9];
  logic signed [31:0] wp3 [3];
  logic signed [31:0] wp4 [3];
  logic signed [63:0] dp [3];
  logic signed [31:0] pt [3];
  logic signed [35:0] s3 [3];
  logic signed [65:0] dot;
  logic signed [65:0] best_dot;
  logic signed [31:0] best_pt [3];
  logic [IW-1:0]      best_idx;
  logic               have_best;

  assign pt[0] = rd_q.x;
  assign pt[1] = rd_q.y;
  assign pt[2] = rd_q.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.scan;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mat_load) begin
      rd_addr <= '0;
    end else if (cmd.scan) begin
      rd_addr <= rd_addr + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_q <= mem[rd_addr];
      idx1 <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr[i*3+j] <= rm[i*3+j] * pt[j];
        end
      end
      idx2 <= idx1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3[i] = 36'(pos[i]) + 36'($signed(pr[i*3][63:30]))
            + 36'($signed(pr[i*3+1][63:30])) + 36'($signed(pr[i*3+2][63:30]));
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      for (int i = 0; i < 3; i++) begin
        wp3[i] <= sat32(66'(s3[i]));
      end
      idx3 <= idx2;
    end
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      for (int i = 0; i < 3; i++) begin
        dp[i]  <= dir[i] * wp3[i];
        wp4[i] <= wp3[i];
      end
      idx4 <= idx3;
    end
  end

  assign dot = 66'(dp[0]) + 66'(dp[1]) + 66'(dp[2]);

  // first strictly greater product wins
  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (cmd.mat_load) begin
      have_best <= 1'b0;
    end else if (v4) begin
      have_best <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && (!have_best || dot > best_dot)) begin
      best_dot <= dot;
      best_idx <= idx4;
      for (int i = 0; i < 3; i++) begin
        best_pt[i] <= wp4[i];
      end
    end
  end

  // bias offset along the normalized direction
  logic signed [63:0] quot [3];
  logic [2:0]         div_busy;

  for (genvar g = 0; g < 3; g++) begin : g_div
    cssu_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (cmd.div_start),
      .dividend (vb[g]),
      .divisor  (len),
      .quot     (quot[g]),
      .busy     (div_busy[g])
    );
  end

  // result register
  logic signed [31:0] sup [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sup[i] = sat32(66'(best_pt[i]) + 66'(quot[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sts.cnt_zero) begin
        rsp_data <= '{sup_x: '0, sup_y: '0, sup_z: '0, best_index: '0, empty_set: 1'b1};
      end else begin
        rsp_data <= '{sup_x: sup[0], sup_y: sup[1], sup_z: sup[2],
                      best_index: 6'(best_idx), empty_set: 1'b0};
      end
    end
  end

  assign sts.cnt_zero  = (count == '0);
  assign sts.scan_last = ({1'b0, CW'(rd_addr)} + CW1'(1)) == {1'b0, count};
  assign sts.pipe_busy = v1 | v2 | v3 | v4;
  assign sts.sqrt_busy = sqrt_busy;
  assign sts.div_busy  = |div_busy;
  assign sts.out_busy  = rsp_valid & ~rsp_ready;

endmodule
`default_nettype wire

// ===== rtl/convex_support_point_search_unit.sv =====
// ---------------------------------------------------------------------------
// convex_support_point_search_unit
// Support point of a stored convex point set for a posed body.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, vec_x..z, pos_x..z, quat_w..z, bias
//   rsp      out  valid/ready   sup_x..z, best_index, empty_set
//
// clear and append complete in idle; a query on an empty store goes straight
// to the result register. for N stored points the scan reads one entry per
// cycle and then drains, while the root unit runs alongside; the offset
// dividers start after both, and the result is loaded once they are done.
// req stays low while a query runs; a held result stalls only the next query.
// reset clears the point count and the control state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module convex_support_point_search_unit
  import cssu_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic         clk,
  input  logic         rst,
  cssu_req_if.sink     req,
  cssu_rsp_if.source   rsp
);

  cmd_t cmd;
  sts_t sts;
  req_t pld;
  rsp_t rsp_data;
  logic rsp_valid;
  logic req_ready;

  assign pld = '{op: req.op, vec_x: req.vec_x, vec_y: req.vec_y, vec_z: req.vec_z,
                 pos_x: req.pos_x, pos_y: req.pos_y, pos_z: req.pos_z,
                 quat_w: req.quat_w, quat_x: req.quat_x, quat_y: req.quat_y,
                 quat_z: req.quat_z, bias: req.bias};

  cssu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .sts       (sts),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  cssu_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pld       (pld),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid)
  );

  assign req.ready      = req_ready;
  assign rsp.valid      = rsp_valid;
  assign rsp.sup_x      = rsp_data.sup_x;
  assign rsp.sup_y      = rsp_data.sup_y;
  assign rsp.sup_z      = rsp_data.sup_z;
  assign rsp.best_index = rsp_data.best_index;
  assign rsp.empty_set  = rsp_data.empty_set;

endmodule
`default_nettype wire

// ===== rtl/cssu_checker.sv =====
// ---------------------------------------------------------------------------
// cssu_checker
// Port-level checks of the support point search unit, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cssu_checker
  import cssu_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic [1:0]         req_op,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic signed [31:0] sup_x,
  input wire logic signed [31:0] sup_y,
  input wire logic signed [31:0] sup_z,
  input wire logic [5:0]         best_index,
  input wire logic               empty_set
);

  // a result held back keeps its value
  `ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(sup_x) && $stable(sup_y) && $stable(sup_z) && $stable(best_index) && $stable(empty_set))

  // a result only leaves through a handshake
  `ASSERT_IMP(a_rsp_drop, clk, rst, $fell(rsp_valid), $past(rsp_ready))

  // an empty query reports all zeros
  `ASSERT_IMP(a_empty_zero, clk, rst, rsp_valid && empty_set, sup_x == 0 && sup_y == 0 && sup_z == 0 && best_index == 0)

  // a query request blocks the next one
  `ASSERT_NXT(a_query_busy, clk, rst, req_valid && req_ready && req_op == OP_QUERY, !req_ready)

endmodule

bind convex_support_point_search_unit cssu_checker u_cssu_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_op     (req.op),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .sup_x      (rsp.sup_x),
  .sup_y      (rsp.sup_y),
  .sup_z      (rsp.sup_z),
  .best_index (rsp.best_index),
  .empty_set  (rsp.empty_set)
);
`default_nettype wire

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the convex support point search unit: a typed-in
// directed table, then random clear/append/query/op-3 traffic checked against a
// bit-accurate predictor of the rotate, scan, normalize and offset arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import cssu_pkg::*;

  localparam int NPTS     = 64;
  localparam int WDOG_MAX = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  cssu_req_if req ();
  cssu_rsp_if rsp ();

  convex_support_point_search_unit #(.MAX_POINTS(NPTS)) dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  // predictor state
  logic signed [31:0] hull_x [NPTS];
  logic signed [31:0] hull_y [NPTS];
  logic signed [31:0] hull_z [NPTS];
  int                 hull_cnt;

  rsp_t support_q [$];
  int   err_cnt;
  int   idle_cnt;
  int   send_idle_pct;
  int   recv_idle_pct;

  typedef struct {
    req_t r;
    bit   chk;
    rsp_t exp_rsp;
  } dir_row_t;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic logic signed [127:0] floor30(input logic signed [127:0] v);
    return v >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // returns 1 when the request yields a support result
  function automatic bit support_of(input req_t r, output rsp_t o);
    logic signed [127:0] v [3], p [3], m [3][3], wp [3], bp [3], s;
    logic signed [127:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, dot, bdot, len, d2;
    logic [63:0] len2;
    o = '0;
    if (r.op == OP_CLEAR) begin
      hull_cnt = 0;
      return 0;
    end
    if (r.op == OP_APPEND) begin
      if (hull_cnt < NPTS) begin
        hull_x[hull_cnt] = r.vec_x;
        hull_y[hull_cnt] = r.vec_y;
        hull_z[hull_cnt] = r.vec_z;
        hull_cnt++;
      end
      return 0;
    end
    if (r.op != OP_QUERY) return 0;
    if (hull_cnt == 0) begin
      o.empty_set = 1'b1;
      return 1;
    end
    v[0] = r.vec_x; v[1] = r.vec_y; v[2] = r.vec_z;
    ww = floor30(128'(r.quat_w) * r.quat_w); xx = floor30(128'(r.quat_x) * r.quat_x);
    yy = floor30(128'(r.quat_y) * r.quat_y); zz = floor30(128'(r.quat_z) * r.quat_z);
    xy = floor30(128'(r.quat_x) * r.quat_y); xz = floor30(128'(r.quat_x) * r.quat_z);
    yz = floor30(128'(r.quat_y) * r.quat_z); wx = floor30(128'(r.quat_w) * r.quat_x);
    wy = floor30(128'(r.quat_w) * r.quat_y); wz = floor30(128'(r.quat_w) * r.quat_z);
    m[0][0] = clamp32(ww + xx - yy - zz); m[1][1] = clamp32(ww - xx + yy - zz);
    m[2][2] = clamp32(ww - xx - yy + zz);
    m[0][1] = clamp32(2 * (xy - wz)); m[0][2] = clamp32(2 * (xz + wy));
    m[1][0] = clamp32(2 * (xy + wz)); m[1][2] = clamp32(2 * (yz - wx));
    m[2][0] = clamp32(2 * (xz - wy)); m[2][1] = clamp32(2 * (yz + wx));
    bdot = 0;
    bp[0] = 0; bp[1] = 0; bp[2] = 0;
    for (int k = 0; k < hull_cnt; k++) begin
      p[0] = hull_x[k]; p[1] = hull_y[k]; p[2] = hull_z[k];
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        case (i)
          0: s = r.pos_x;
          1: s = r.pos_y;
          default: s = r.pos_z;
        endcase
        for (int j = 0; j < 3; j++) s = s + floor30(m[i][j] * p[j]);
        wp[i] = clamp32(s);
        dot = dot + v[i] * wp[i];
      end
      // first strictly greater product wins
      if (k == 0 || dot > bdot) begin
        bdot = dot;
        o.best_index = k[5:0];
        bp = wp;
      end
    end
    len2 = 64'(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
    len = {64'd0, root64(len2)};
    for (int i = 0; i < 3; i++) begin
      d2 = 0;
      if (len != 0) d2 = (v[i] * r.bias) / len;
      s = clamp32(bp[i] + d2);
      case (i)
        0: o.sup_x = s[31:0];
        1: o.sup_y = s[31:0];
        default: o.sup_z = s[31:0];
      endcase
    end
    return 1;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [31:0] rand_quat();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h40000000;
      default: return 32'($signed($urandom_range(0, 1 << 31)) - (1 << 30));
    endcase
  endfunction

  function automatic req_t rand_req(input int mode);
    req_t r;
    r.vec_x = rand_coord(); r.vec_y = rand_coord(); r.vec_z = rand_coord();
    r.pos_x = rand_coord(); r.pos_y = rand_coord(); r.pos_z = rand_coord();
    r.quat_w = rand_quat(); r.quat_x = rand_quat();
    r.quat_y = rand_quat(); r.quat_z = rand_quat();
    r.bias = rand_coord();
    case (mode)
      0: r.op = OP_CLEAR;
      1: r.op = OP_APPEND;
      2: r.op = OP_QUERY;
      default: r.op = 2'd3;
    endcase
    return r;
  endfunction

  // valid stays high after the request; the next call or the caller drops it
  task automatic send(input req_t r, input bit chk, input rsp_t want);
    rsp_t o;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= r.op;
    req.vec_x <= r.vec_x; req.vec_y <= r.vec_y; req.vec_z <= r.vec_z;
    req.pos_x <= r.pos_x; req.pos_y <= r.pos_y; req.pos_z <= r.pos_z;
    req.quat_w <= r.quat_w; req.quat_x <= r.quat_x;
    req.quat_y <= r.quat_y; req.quat_z <= r.quat_z;
    req.bias <= r.bias;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (support_of(r, o)) begin
      if (chk) support_q.insert(support_q.size(), want);
      else support_q.insert(support_q.size(), o);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.sup_x, rsp.sup_y, rsp.sup_z, rsp.best_index, rsp.empty_set};
      if (support_q.size() == 0) begin
        report("unexpected result", '0, '0);
      end else begin
        want = support_q.pop_front();
        if (got.sup_x !== want.sup_x) report("sup_x", 64'(got.sup_x), 64'(want.sup_x));
        if (got.sup_y !== want.sup_y) report("sup_y", 64'(got.sup_y), 64'(want.sup_y));
        if (got.sup_z !== want.sup_z) report("sup_z", 64'(got.sup_z), 64'(want.sup_z));
        if (got.best_index !== want.best_index)
          report("best_index", 64'(got.best_index), 64'(want.best_index));
        if (got.empty_set !== want.empty_set)
          report("empty_set", 64'(got.empty_set), 64'(want.empty_set));
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_MAX) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t d;
    req_t     r;
    rsp_t     none;
    int       mode;
    err_cnt = 0;
    idle_cnt = 0;
    send_idle_pct = 25;
    recv_idle_pct = 64;
    hull_cnt = 0;
    none = '0;
    req.valid = 1'b0;
    req.op = OP_CLEAR;
    {req.vec_x, req.vec_y, req.vec_z, req.pos_x, req.pos_y, req.pos_z} = '0;
    {req.quat_w, req.quat_x, req.quat_y, req.quat_z, req.bias} = '0;
    rsp.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty query, identity pose, extremes, ties, zero direction, op 3
    d.r = '0; d.r.op = OP_QUERY; d.chk = 1; d.exp_rsp = '0; d.exp_rsp.empty_set = 1;
    rows.insert(rows.size(), d);
    d.chk = 0;
    d.r = '0; d.r.op = OP_APPEND; d.r.vec_x = 32'sh00010000; rows.insert(rows.size(), d);
    d.r = '0; d.r.op = OP_APPEND; d.r.vec_y = 32'sh00020000; rows.insert(rows.size(), d);
    d.r = '0; d.r.op = OP_APPEND; d.r.vec_x = 32'sh7fffffff;
    d.r.vec_y = 32'sh80000000; d.r.vec_z = 32'sh7fffffff; rows.insert(rows.size(), d);
    d.r = '0; d.r.op = OP_APPEND; d.r.vec_x = 32'sh00010000; rows.insert(rows.size(), d);
    d.r = '0; d.r.op = OP_QUERY; d.r.quat_w = 32'sh40000000;
    d.r.vec_y = 32'sh00010000; rows.insert(rows.size(), d);
    d.r.vec_y = 0; rows.insert(rows.size(), d);
    d.r = '{OP_QUERY, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
            32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    rows.insert(rows.size(), d);
    d.r.bias = 32'sh80000000; d.r.quat_w = 32'sh7fffffff; rows.insert(rows.size(), d);
    d.r = '1; d.r.op = 2'd3; rows.insert(rows.size(), d);
    d.r = '1; d.r.op = OP_QUERY; rows.insert(rows.size(), d);
    d.r = '0; d.r.op = OP_CLEAR; rows.insert(rows.size(), d);
    d.r = '0; d.r.op = OP_QUERY; d.chk = 1; d.exp_rsp = '0; d.exp_rsp.empty_set = 1;
    rows.insert(rows.size(), d);
    d.chk = 0;
    foreach (rows[i]) send(rows[i].r, rows[i].chk, rows[i].exp_rsp);

    // fill past the limit so appends to a full store are dropped
    for (int i = 0; i < NPTS + 3; i++) send(rand_req(1), 0, none);
    send(rand_req(2), 0, none);
    req.valid <= 1'b0;
    // hold off until all results are home
    while (support_q.size() != 0) @(posedge clk);

    for (int n = 0; n < 2000; n++) begin
      if (n == 700) begin
        send_idle_pct = 64;
        recv_idle_pct = 25;
      end
      if (n == 1400) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // mostly small hulls so queries stay short; sometimes grow past twelve
      mode = $urandom_range(0, 99);
      if (mode < 4) r = rand_req(0);
      else if (mode < 58) r = rand_req(1);
      else if (mode < 97) r = rand_req(2);
      else r = rand_req(3);
      if (r.op == OP_APPEND && hull_cnt >= 12 && $urandom_range(0, 9) != 0) r = rand_req(0);
      if (r.op == OP_QUERY && $urandom_range(0, 19) == 0) begin
        r.vec_x = 0; r.vec_y = 0; r.vec_z = 0;
      end
      send(r, 0, none);
    end
    req.valid <= 1'b0;

    while (support_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
